[rtl/butterworth_biquad_coef_calc_assert.svh]
// Assertion macros for the checker file of the coefficient calculator.
`ifndef BUTTERWORTH_BIQUAD_COEF_CALC_ASSERT_SVH
`define BUTTERWORTH_BIQUAD_COEF_CALC_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define BBC_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bbc assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define BBC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bbc assertion failed");

`endif

[rtl/bbc_pkg.sv]
// Shared types, widths, constants and the arctangent table of the biquad coefficient calculator.
package bbc_pkg;

	localparam int FREQ_BITS      = 24;
	localparam int COEF_FRAC_BITS = 28;
	localparam int COEF_W         = 32;
	localparam int PHASE_BITS     = 32;
	localparam int CORDIC_STEPS   = 30;
	localparam int VAL_W          = 34;
	localparam int ZW             = 33;
	localparam int DEN_W          = 33;
	localparam int Q_W            = 32;
	localparam int DIVD_W         = 2 * Q_W;
	localparam int NUM_COEF       = 4;
	localparam int IN_W           = 32;
	localparam int OUT_W          = 5 * COEF_W;

	localparam logic signed [VAL_W-1:0] CORDIC_X0 = 34'sd652032874;
	localparam logic signed [VAL_W-1:0] ONE_Q30   = 34'sd1073741824;
	localparam logic signed [VAL_W-1:0] TWO_Q30   = 34'sd2147483648;
	localparam logic signed [31:0]      SQRT2_Q30 = 32'sd1518500250;

	localparam logic [3:0] ORDER_TWO = 4'd2;

	typedef enum logic [1:0] {
		MODE_LOW_PASS  = 2'd0,
		MODE_HIGH_PASS = 2'd1,
		MODE_RSVD_A    = 2'd2,
		MODE_RSVD_B    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK         = 2'd0,
		STAT_BAD_ORDER  = 2'd1,
		STAT_BAD_MODE   = 2'd2,
		STAT_BAD_CUTOFF = 2'd3
	} status_t;

	typedef struct packed {
		logic    valid;
		status_t status;
		logic    hp;
	} tag_t;

	// Arctangent of 2^-i in units of 2^-32 turn.
	localparam logic signed [ZW-1:0] ATAN_TURN [CORDIC_STEPS] = '{
		33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
		33'sd42667331, 33'sd21354465, 33'sd10679838, 33'sd5340245,
		33'sd2670163, 33'sd1335087, 33'sd667544, 33'sd333772,
		33'sd166886, 33'sd83443, 33'sd41722, 33'sd20861,
		33'sd10430, 33'sd5215, 33'sd2608, 33'sd1304,
		33'sd652, 33'sd326, 33'sd163, 33'sd81,
		33'sd41, 33'sd20, 33'sd10, 33'sd5,
		33'sd3, 33'sd1
	};

endpackage

[rtl/bbc_phase_div.sv]
// Pipelined restoring divider: phase = floor(cutoff * 2^32 / sample rate).
module bbc_phase_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  bbc_pkg::tag_t                 tag_in,
	input  logic [bbc_pkg::FREQ_BITS-1:0] fc_in,
	input  logic [bbc_pkg::FREQ_BITS-1:0] fs,
	output bbc_pkg::tag_t                 tag_out,
	output logic [bbc_pkg::PHASE_BITS-1:0] phase_out
);
	import bbc_pkg::*;

	tag_t                  tag_s [1:PHASE_BITS];
	logic [FREQ_BITS-1:0]  rem_s [1:PHASE_BITS];
	logic [PHASE_BITS-1:0] quo_s [1:PHASE_BITS];

	for (genvar k = 1; k <= PHASE_BITS; k++) begin : g_step
		tag_t                  tag_prev;
		logic [FREQ_BITS-1:0]  rem_prev;
		logic [PHASE_BITS-1:0] quo_prev;
		logic [FREQ_BITS:0]    r2;
		logic                  ge;

		if (k == 1) begin : g_first
			assign tag_prev = tag_in;
			assign rem_prev = fc_in;
			assign quo_prev = '0;
		end else begin : g_next
			assign tag_prev = tag_s[k-1];
			assign rem_prev = rem_s[k-1];
			assign quo_prev = quo_s[k-1];
		end

		assign r2 = {rem_prev, 1'b0};
		assign ge = r2 >= {1'b0, fs};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[k] <= '0;
			end else if (en) begin
				tag_s[k] <= tag_prev;
			end
		end

		// one quotient bit per stage
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? FREQ_BITS'(r2 - {1'b0, fs}) : FREQ_BITS'(r2);
				quo_s[k] <= {quo_prev[PHASE_BITS-2:0], ge};
			end
		end
	end

	assign tag_out   = tag_s[PHASE_BITS];
	assign phase_out = quo_s[PHASE_BITS];

endmodule

[rtl/bbc_cordic.sv]
// Pipelined rotation-mode CORDIC: sine and cosine of the folded phase.
module bbc_cordic (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  bbc_pkg::tag_t                       tag_in,
	input  logic [bbc_pkg::PHASE_BITS-1:0]      phase_in,
	output bbc_pkg::tag_t                       tag_out,
	output logic signed [bbc_pkg::VAL_W-1:0]    x_out,
	output logic signed [bbc_pkg::VAL_W-1:0]    y_out,
	output logic                                flip_out
);
	import bbc_pkg::*;

	tag_t                    tag_s  [0:CORDIC_STEPS];
	logic                    flip_s [0:CORDIC_STEPS];
	logic signed [ZW-1:0]    z_s    [0:CORDIC_STEPS-1];
	logic signed [VAL_W-1:0] x_s    [1:CORDIC_STEPS];
	logic signed [VAL_W-1:0] y_s    [1:CORDIC_STEPS];

	logic flip_in;

	// fold angles above a quarter turn back into range
	assign flip_in = phase_in > 32'h4000_0000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s[0] <= '0;
		end else if (en) begin
			tag_s[0] <= tag_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flip_s[0] <= flip_in;
			z_s[0]    <= flip_in ? ZW'(33'sh0_8000_0000 - {1'b0, phase_in})
			                     : ZW'({1'b0, phase_in});
		end
	end

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
		logic signed [VAL_W-1:0] xp;
		logic signed [VAL_W-1:0] yp;
		logic signed [VAL_W-1:0] dx;
		logic signed [VAL_W-1:0] dy;
		logic                    up;

		if (k == 0) begin : g_first
			assign xp = CORDIC_X0;
			assign yp = '0;
		end else begin : g_next
			assign xp = x_s[k];
			assign yp = y_s[k];
		end

		assign dx = yp >>> k;
		assign dy = xp >>> k;
		assign up = !z_s[k][ZW-1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[k+1] <= '0;
			end else if (en) begin
				tag_s[k+1] <= tag_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k+1]    <= up ? xp - dx : xp + dx;
				y_s[k+1]    <= up ? yp + dy : yp - dy;
				flip_s[k+1] <= flip_s[k];
			end
		end

		if (k < CORDIC_STEPS - 1) begin : g_z
			always_ff @(posedge clk) begin
				if (en) begin
					z_s[k+1] <= up ? z_s[k] - ATAN_TURN[k] : z_s[k] + ATAN_TURN[k];
				end
			end
		end
	end

	assign tag_out  = tag_s[CORDIC_STEPS];
	assign x_out    = x_s[CORDIC_STEPS];
	assign y_out    = y_s[CORDIC_STEPS];
	assign flip_out = flip_s[CORDIC_STEPS];

endmodule

[rtl/bbc_coef_prep.sv]
// Scales the sine by sqrt2 and forms the four numerators and the denominator.
module bbc_coef_prep (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  bbc_pkg::tag_t                    tag_in,
	input  logic signed [bbc_pkg::VAL_W-1:0] x_in,
	input  logic signed [bbc_pkg::VAL_W-1:0] y_in,
	input  logic                             flip_in,
	output bbc_pkg::tag_t                    tag_out,
	output logic signed [bbc_pkg::VAL_W-1:0] num_out [bbc_pkg::NUM_COEF],
	output logic [bbc_pkg::DEN_W-1:0]        den_out
);
	import bbc_pkg::*;

	tag_t                    tag_s1;
	tag_t                    tag_s2;
	logic signed [VAL_W-1:0] c_s1;
	logic signed [63:0]      prod_s1;
	logic signed [VAL_W-1:0] num_s2 [NUM_COEF];
	logic [DEN_W-1:0]        den_s2;

	logic signed [31:0]      s_val;
	logic signed [VAL_W-1:0] t_val;
	logic signed [VAL_W-1:0] bnum;
	logic signed [VAL_W-1:0] bnum2;
	logic signed [VAL_W-1:0] den_full;

	assign s_val    = 32'(y_in);
	assign t_val    = VAL_W'(prod_s1 >>> 30);
	assign bnum     = tag_s1.hp ? ONE_Q30 + c_s1 : ONE_Q30 - c_s1;
	assign bnum2    = bnum <<< 1;
	assign den_full = TWO_Q30 + t_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else if (en) begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1      <= flip_in ? -x_in : x_in;
			prod_s1   <= 64'(s_val) * 64'(SQRT2_Q30);
			num_s2[0] <= bnum;
			num_s2[1] <= tag_s1.hp ? -bnum2 : bnum2;
			num_s2[2] <= -(c_s1 <<< 2);
			num_s2[3] <= TWO_Q30 - t_val;
			den_s2    <= DEN_W'(den_full);
		end
	end

	assign tag_out = tag_s2;
	assign num_out = num_s2;
	assign den_out = den_s2;

endmodule

[rtl/bbc_coef_div.sv]
// Four-lane pipelined divider with rounding and Q3.28 saturation.
module bbc_coef_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  bbc_pkg::tag_t                     tag_in,
	input  logic signed [bbc_pkg::VAL_W-1:0]  num_in [bbc_pkg::NUM_COEF],
	input  logic [bbc_pkg::DEN_W-1:0]         den_in,
	output bbc_pkg::tag_t                     tag_out,
	output logic [bbc_pkg::COEF_W-1:0]        coef_out [bbc_pkg::NUM_COEF]
);
	import bbc_pkg::*;

	tag_t             tag_s [0:Q_W];
	logic [DEN_W-1:0] den_s [0:Q_W];
	logic [DEN_W-1:0] rem_s  [0:Q_W][NUM_COEF];
	logic [Q_W-1:0]   work_s [0:Q_W][NUM_COEF];
	logic             neg_s  [0:Q_W][NUM_COEF];
	tag_t             tag_q;
	logic [COEF_W-1:0] coef_q [NUM_COEF];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s[0] <= '0;
			tag_q    <= '0;
		end else if (en) begin
			tag_s[0] <= tag_in;
			tag_q    <= tag_s[Q_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0] <= den_in;
		end
	end

	for (genvar l = 0; l < NUM_COEF; l++) begin : g_lane
		logic [VAL_W-1:0]  mag;
		logic [DIVD_W-1:0] dvd;
		logic [Q_W-1:0]    q;

		// magnitude scaled by 2^frac, plus half the divisor for rounding
		assign mag = num_in[l][VAL_W-1] ? VAL_W'(-num_in[l]) : VAL_W'(num_in[l]);
		assign dvd = DIVD_W'({mag, {COEF_FRAC_BITS{1'b0}}}) + DIVD_W'(den_in >> 1);
		assign q   = work_s[Q_W][l];

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[0][l]  <= DEN_W'(dvd[DIVD_W-1:Q_W]);
				work_s[0][l] <= dvd[Q_W-1:0];
				neg_s[0][l]  <= num_in[l][VAL_W-1];
				if (!neg_s[Q_W][l]) begin
					coef_q[l] <= q[Q_W-1] ? {1'b0, {(COEF_W-1){1'b1}}} : q;
				end else begin
					coef_q[l] <= (q > {1'b1, {(Q_W-1){1'b0}}}) ? {1'b1, {(COEF_W-1){1'b0}}}
					                                           : COEF_W'(-q);
				end
			end
		end
	end

	for (genvar k = 0; k < Q_W; k++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[k+1] <= '0;
			end else if (en) begin
				tag_s[k+1] <= tag_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k+1] <= den_s[k];
			end
		end

		for (genvar l = 0; l < NUM_COEF; l++) begin : g_lane
			logic [DEN_W:0] r2;
			logic           ge;

			assign r2 = {rem_s[k][l], work_s[k][l][Q_W-1]};
			assign ge = r2 >= {1'b0, den_s[k]};

			// shift in the next dividend bit, shift out a quotient bit
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1][l]  <= ge ? DEN_W'(r2 - {1'b0, den_s[k]}) : DEN_W'(r2);
					work_s[k+1][l] <= {work_s[k][l][Q_W-2:0], ge};
					neg_s[k+1][l]  <= neg_s[k][l];
				end
			end
		end
	end

	assign tag_out  = tag_q;
	assign coef_out = coef_q;

endmodule

[rtl/butterworth_biquad_coef_calc.sv]
// Top level of the second-order Butterworth biquad coefficient calculator.
//
// Input channel s_*: one item per filter request (mode, order, cutoff in hertz).
// Output channel m_*: one item per request, status on m_tuser and the five
// coefficients b0, b1, b2, a1, a2 in signed Q3.28 on m_tdata; a0 is always 1.
// Rejected requests (bad order, bad mode, cutoff zero or at/above fs/2) come
// out in order with their status code and all coefficients zero.
// cfg_we/cfg_wdata write the sampling rate; write it only while idle.
//
// The pipeline has 32 phase divider stages, 31 CORDIC stages, 2 scaling
// stages and 34 coefficient divider stages.
// Throughput is one item per cycle while the receiver does not stall; most
// stages are a register step of one divider bit, one CORDIC rotation or one multiply.
// Reset clears all valid bits and loads 48000 Hz as the sampling rate.
// When the receiver stalls, the whole pipeline holds in place and s_tready
// drops in the same cycle; nothing is lost or repeated.
module butterworth_biquad_coef_calc (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [bbc_pkg::IN_W-1:0]      s_tdata,   // filter_mode, filter_order, cutoff_hz, pad
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [bbc_pkg::OUT_W-1:0]     m_tdata,   // coef_b0, coef_b1, coef_b2, coef_a1, coef_a2
	output logic [1:0]                    m_tuser,   // status
	input  logic                          cfg_we,
	input  logic [bbc_pkg::FREQ_BITS-1:0] cfg_wdata
);
	import bbc_pkg::*;

	logic [FREQ_BITS-1:0] sample_rate_q;

	logic                 en;
	mode_t                mode;
	logic [3:0]           order;
	logic [FREQ_BITS-1:0] cutoff;
	status_t              status_in;
	tag_t                 tag_in;

	tag_t                    tag_div;
	logic [PHASE_BITS-1:0]   phase;
	tag_t                    tag_cor;
	logic signed [VAL_W-1:0] x_cor;
	logic signed [VAL_W-1:0] y_cor;
	logic                    flip_cor;
	tag_t                    tag_prep;
	logic signed [VAL_W-1:0] num_prep [NUM_COEF];
	logic [DEN_W-1:0]        den_prep;
	tag_t                    tag_fin;
	logic [COEF_W-1:0]       coef_fin [NUM_COEF];
	logic                    ok_fin;

	// sampling rate register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_rate_q <= FREQ_BITS'(48000);
		end else if (cfg_we) begin
			sample_rate_q <= cfg_wdata;
		end
	end

	// the whole pipeline advances unless a finished item is being held
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	assign mode   = mode_t'(s_tdata[1:0]);
	assign order  = s_tdata[5:2];
	assign cutoff = s_tdata[29:6];

	// screen the request: order first, then mode, then cutoff range
	always_comb begin
		priority if (order != ORDER_TWO) begin
			status_in = STAT_BAD_ORDER;
		end else if (mode != MODE_LOW_PASS && mode != MODE_HIGH_PASS) begin
			status_in = STAT_BAD_MODE;
		end else if (cutoff == '0 || {cutoff, 1'b0} >= {1'b0, sample_rate_q}) begin
			status_in = STAT_BAD_CUTOFF;
		end else begin
			status_in = STAT_OK;
		end
	end

	assign tag_in.valid  = s_tvalid;
	assign tag_in.status = status_in;
	assign tag_in.hp     = (mode == MODE_HIGH_PASS);

	bbc_phase_div u_phase_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.tag_in   (tag_in),
		.fc_in    (cutoff),
		.fs       (sample_rate_q),
		.tag_out  (tag_div),
		.phase_out(phase)
	);

	bbc_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.tag_in  (tag_div),
		.phase_in(phase),
		.tag_out (tag_cor),
		.x_out   (x_cor),
		.y_out   (y_cor),
		.flip_out(flip_cor)
	);

	bbc_coef_prep u_coef_prep (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.tag_in (tag_cor),
		.x_in   (x_cor),
		.y_in   (y_cor),
		.flip_in(flip_cor),
		.tag_out(tag_prep),
		.num_out(num_prep),
		.den_out(den_prep)
	);

	bbc_coef_div u_coef_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.tag_in  (tag_prep),
		.num_in  (num_prep),
		.den_in  (den_prep),
		.tag_out (tag_fin),
		.coef_out(coef_fin)
	);

	// drop the coefficients of rejected items; b2 repeats b0
	assign ok_fin   = (tag_fin.status == STAT_OK);
	assign m_tvalid = tag_fin.valid;
	assign m_tuser  = tag_fin.status;
	assign m_tdata  = ok_fin ? {coef_fin[3], coef_fin[2], coef_fin[0], coef_fin[1], coef_fin[0]}
	                         : '0;

endmodule

[rtl/bbc_checker.sv]
// Port-level checker of the coefficient calculator, bound to the top level.
`include "butterworth_biquad_coef_calc_assert.svh"

module bbc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [bbc_pkg::OUT_W-1:0]     m_tdata,
	input logic [1:0]                    m_tuser
);
	import bbc_pkg::*;

	// a held output keeps its contents
	`BBC_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// input side stalls exactly when a result is held
	`BBC_ASSERT_IMPLY(a_ready, 1'b1, s_tready == (!m_tvalid || m_tready))

	// rejected items carry no coefficients
	`BBC_ASSERT_IMPLY(a_reject_zero, m_tvalid && m_tuser != STAT_OK, m_tdata == '0)

	// b2 always equals b0
	`BBC_ASSERT_IMPLY(a_b2_b0, m_tvalid, m_tdata[95:64] == m_tdata[31:0])

endmodule

bind butterworth_biquad_coef_calc bbc_checker u_bbc_checker (.*);
